FILE: rtl/core/sedd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_pkg
// Shared constants, command codes, types and size helpers for the serpentine
// error diffusion dither.
// ----------------------------------------------------------------------------
package sedd_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    localparam int CFG_W  = 11;
    localparam int CIDX_W = 1;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int POS_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROWC_W = $clog2(MAX_HEIGHT);
    localparam int HGT_W  = $clog2(MAX_HEIGHT + 1);

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_SEED  = 2'd1;
    localparam logic [1:0] CMD_PIXEL = 2'd2;

    localparam logic [CIDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CIDX_W-1:0] REG_HEIGHT = 1'b1;

    localparam logic [CFG_W-1:0] WIDTH_RST  = 11'd1024;
    localparam logic [CFG_W-1:0] HEIGHT_RST = 11'd768;

    localparam logic signed [10:0] SUM_THRESH = 11'sd127;
    localparam logic signed [10:0] SUM_FULL   = 11'sd255;
    localparam logic signed [7:0]  SEED_BIAS  = 8'sd7;

    typedef struct packed {
        logic [1:0]       cmd;
        logic [7:0]       pixel_value;
        logic [3:0]       noise_value;
        logic [COL_W-1:0] addr;
        logic             wr_seed;
        logic             rev;
        logic             acc_clr;
        logic             emit;
        logic             row_end;
        logic             frame_end;
    } t_stage;

    function automatic logic [POS_W-1:0] f_eff_width(input logic [CFG_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd8) x = 32'd8;
        if (x > 32'(MAX_WIDTH)) x = 32'(MAX_WIDTH);
        x[2:0] = 3'd0;
        return POS_W'(x);
    endfunction

    function automatic logic [HGT_W-1:0] f_eff_height(input logic [CFG_W-1:0] v);
        logic [31:0] x;
        x = 32'(v);
        if (x < 32'd2) x = 32'd2;
        if (x > 32'(MAX_HEIGHT)) x = 32'(MAX_HEIGHT);
        x[0] = 1'b0;
        return HGT_W'(x);
    endfunction

    function automatic logic signed [7:0] f_seed(input logic [3:0] noise);
        return $signed({4'd0, noise}) - SEED_BIAS;
    endfunction

endpackage

FILE: rtl/core/sedd_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_in_if
// Input channel: command, pixel and noise with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sedd_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] pixel_value;
    logic [3:0] noise_value;

    modport source (output valid, cmd, pixel_value, noise_value, input ready);
    modport sink   (input valid, cmd, pixel_value, noise_value, output ready);
endinterface

FILE: rtl/core/sedd_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_out_if
// Output channel: one packed byte of dithered pixels with its position flags.
// ----------------------------------------------------------------------------
interface sedd_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_bits;
    logic [6:0] byte_index;
    logic       row_end;
    logic       frame_end;

    modport source (output valid, packed_bits, byte_index, row_end, frame_end,
                    input ready);
    modport sink   (input valid, packed_bits, byte_index, row_end, frame_end,
                    output ready);
endinterface

FILE: rtl/core/sedd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_front
// Configuration registers, scan position bookkeeping and the input register.
// ----------------------------------------------------------------------------
module sedd_front
    import sedd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    sedd_in_if.sink           s_in,
    input  logic              i_adv,
    output logic              o_stage_v,
    output t_stage            o_stage,
    output logic              o_rd_en,
    output logic [COL_W-1:0]  o_rd_addr
);

    logic [CFG_W-1:0]  r_width;
    logic [CFG_W-1:0]  r_height;
    logic [COL_W-1:0]  r_colpos, n_colpos;
    logic [POS_W-1:0]  r_seed, n_seed;
    logic              r_rev, n_rev;
    logic [ROWC_W-1:0] r_row, n_row;
    logic              r_v;
    t_stage            r_stage, n_stage;

    logic [POS_W-1:0]  w_eff;
    logic [HGT_W-1:0]  h_eff;
    logic              restart, rowwrap, rev, emit, row_done, frame_done, seed_ok;
    logic [COL_W-1:0]  pos, col;
    logic [ROWC_W-1:0] rowc;
    logic [POS_W-1:0]  pos_nx;
    logic [HGT_W-1:0]  row_nx;
    logic              acc;

    assign w_eff   = f_eff_width(r_width);
    assign h_eff   = f_eff_height(r_height);
    assign restart = POS_W'(r_colpos) >= w_eff;
    assign rowwrap = HGT_W'(r_row) >= h_eff;
    assign pos     = restart ? '0 : r_colpos;
    assign rev     = rowwrap ? 1'b0 : r_rev;
    assign rowc    = rowwrap ? '0 : r_row;
    assign col     = rev ? COL_W'(w_eff - POS_W'(1) - POS_W'(pos)) : pos;
    assign pos_nx  = POS_W'(pos) + POS_W'(1);
    assign emit    = pos_nx[2:0] == 3'd0;
    assign row_done   = emit && (pos_nx >= w_eff);
    assign row_nx     = HGT_W'(rowc) + HGT_W'(1);
    assign frame_done = row_done && (row_nx >= h_eff);
    assign seed_ok    = r_seed < w_eff;

    assign s_in.ready = !r_v || i_adv;
    assign acc        = s_in.valid && s_in.ready;
    assign o_rd_en    = acc;
    assign o_rd_addr  = col;
    assign o_stage_v  = r_v;
    assign o_stage    = r_stage;

    always_comb begin
        n_colpos = r_colpos;
        n_seed   = r_seed;
        n_rev    = r_rev;
        n_row    = r_row;
        n_stage.cmd         = s_in.cmd;
        n_stage.pixel_value = s_in.pixel_value;
        n_stage.noise_value = s_in.noise_value;
        n_stage.addr        = col;
        n_stage.wr_seed     = 1'b0;
        n_stage.rev         = rev;
        n_stage.acc_clr     = restart;
        n_stage.emit        = 1'b0;
        n_stage.row_end     = 1'b0;
        n_stage.frame_end   = 1'b0;
        case (s_in.cmd)
            CMD_START: begin
                n_colpos = '0;
                n_seed   = '0;
                n_rev    = 1'b0;
                n_row    = '0;
            end
            CMD_SEED: begin
                n_stage.addr    = COL_W'(r_seed);
                n_stage.wr_seed = seed_ok;
                if (seed_ok) begin
                    n_seed = r_seed + POS_W'(1);
                end
            end
            CMD_PIXEL: begin
                n_stage.emit      = emit;
                n_stage.row_end   = row_done;
                n_stage.frame_end = frame_done;
                n_colpos = row_done ? '0 : COL_W'(pos_nx);
                if (frame_done) begin
                    n_rev = 1'b0;
                    n_row = '0;
                end else if (row_done) begin
                    n_rev = !rev;
                    n_row = ROWC_W'(row_nx);
                end else begin
                    n_rev = rev;
                    n_row = rowc;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_WIDTH:  r_width  <= i_cfg_data;
                REG_HEIGHT: r_height <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_colpos <= '0;
            r_seed   <= '0;
            r_rev    <= 1'b0;
            r_row    <= '0;
            r_v      <= 1'b0;
        end else if (acc) begin
            r_colpos <= n_colpos;
            r_seed   <= n_seed;
            r_rev    <= n_rev;
            r_row    <= n_row;
            r_v      <= 1'b1;
        end else if (i_adv) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_stage <= n_stage;
        end
    end

endmodule

FILE: rtl/core/sedd_errmem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_errmem
// Column error store: one write and one registered read per cycle, with a
// bypass for a write that lands on the address read in the same cycle.
// ----------------------------------------------------------------------------
module sedd_errmem
    import sedd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [COL_W-1:0]  i_rd_addr,
    input  logic              i_wr_en,
    input  logic [COL_W-1:0]  i_wr_addr,
    input  logic signed [7:0] i_wr_data,
    output logic signed [7:0] o_rd_data
);

    logic signed [7:0] r_mem [MAX_WIDTH];
    logic signed [7:0] r_rd;
    logic signed [7:0] r_byp_data;
    logic              r_byp;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd       <= r_mem[i_rd_addr];
            r_byp      <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_byp ? r_byp_data : r_rd;

endmodule

FILE: rtl/core/sedd_diffuse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_diffuse
// Threshold and error diffusion for one item, bit packing and the output
// register.
// ----------------------------------------------------------------------------
module sedd_diffuse
    import sedd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_stage_v,
    input  t_stage            i_stage,
    input  logic signed [7:0] i_col_err,
    output logic              o_adv,
    output logic              o_wr_en,
    output logic [COL_W-1:0]  o_wr_addr,
    output logic signed [7:0] o_wr_data,
    sedd_out_if.source        m_out
);

    logic signed [7:0] r_carry;
    logic [7:0]        r_acc, n_acc;
    logic              r_out_v;
    logic [7:0]        r_bits;
    logic [6:0]        r_idx;
    logic              r_row_end, r_frame_end;

    logic signed [10:0] sum, e;
    logic signed [7:0]  err;
    logic               dark;
    logic [7:0]         base;
    logic               is_pix;

    assign is_pix = i_stage.cmd == CMD_PIXEL;
    assign o_adv  = i_stage_v && (!i_stage.emit || !r_out_v || m_out.ready);

    assign sum  = $signed({3'd0, i_stage.pixel_value}) + 11'(r_carry) + 11'(i_col_err);
    assign dark = !(sum > SUM_THRESH);
    assign e    = dark ? sum : sum - SUM_FULL;
    assign err  = 8'((e + $signed({10'd0, e[10]})) >>> 1);
    assign base = i_stage.acc_clr ? 8'd0 : r_acc;
    assign n_acc = i_stage.rev ? {dark, base[7:1]} : {base[6:0], dark};

    assign o_wr_en   = o_adv && (is_pix || i_stage.wr_seed);
    assign o_wr_addr = i_stage.addr;
    assign o_wr_data = is_pix ? err : f_seed(i_stage.noise_value);

    assign m_out.valid       = r_out_v;
    assign m_out.packed_bits = r_bits;
    assign m_out.byte_index  = r_idx;
    assign m_out.row_end     = r_row_end;
    assign m_out.frame_end   = r_frame_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_carry <= '0;
            r_acc   <= '0;
            r_out_v <= 1'b0;
        end else begin
            if (o_adv && is_pix && i_stage.emit) begin
                r_out_v <= 1'b1;
            end else if (m_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (o_adv) begin
                case (i_stage.cmd)
                    CMD_START: begin
                        r_carry <= f_seed(i_stage.noise_value);
                        r_acc   <= '0;
                    end
                    CMD_PIXEL: begin
                        r_carry <= err;
                        r_acc   <= i_stage.emit ? 8'd0 : n_acc;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && is_pix && i_stage.emit) begin
            r_bits      <= n_acc;
            r_idx       <= 7'(i_stage.addr >> 3);
            r_row_end   <= i_stage.row_end;
            r_frame_end <= i_stage.frame_end;
        end
    end

endmodule

FILE: rtl/core/serpentine_error_diffusion_dither.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// serpentine_error_diffusion_dither
// Serpentine error diffusion of 8-bit gray pixels into packed 1-bit pixels.
//
//   Channel  Dir  Payload                                     Transfer
//   i_in     in   cmd, pixel_value, noise_value               valid & ready
//   o_out    out  packed_bits, byte_index, row_end, frame_end valid & ready
//   cfg      in   i_cfg_idx, i_cfg_data                       i_cfg_we
//
// One item is taken per clock while no stalled output byte holds it back. A
// byte is valid once the output register takes it after the transfer of its
// eighth pixel: the input register and the registered column error read load
// at the same edge, and the threshold and diffusion then fill the output register when the stage advances.
// Reset is synchronous and clears the position, carry and output state; the
// column error store is not cleared and must be seeded before use.
// A stalled output byte holds the input back only once a second byte is due.
// ----------------------------------------------------------------------------
module serpentine_error_diffusion_dither
    import sedd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CIDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    sedd_in_if.sink           i_in,
    sedd_out_if.source        o_out
);

    logic              stage_v;
    t_stage            stage;
    logic              adv;
    logic              rd_en;
    logic [COL_W-1:0]  rd_addr;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic signed [7:0] wr_data;
    logic signed [7:0] rd_data;

    sedd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (i_in),
        .i_adv      (adv),
        .o_stage_v  (stage_v),
        .o_stage    (stage),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr)
    );

    sedd_errmem u_errmem (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    sedd_diffuse u_diffuse (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stage_v (stage_v),
        .i_stage   (stage),
        .i_col_err (rd_data),
        .o_adv     (adv),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .m_out     (o_out)
    );

endmodule

FILE: rtl/core/sedd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sedd_checker
// Port-level checks for the dither, attached to the top level by bind.
// ----------------------------------------------------------------------------
module sedd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_bits,
    input logic       i_out_row_end,
    input logic       i_out_frame_end
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_bits))
        else $error("stalled output transfer changed");

    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_frame_end |-> i_out_row_end)
        else $error("frame end without row end");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in_ready |-> i_out_valid)
        else $error("input stalled with no output pending");

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2))
        else $error("output byte without a matching input transfer");

endmodule

bind serpentine_error_diffusion_dither sedd_checker u_sedd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in.valid),
    .i_in_ready      (i_in.ready),
    .i_out_valid     (o_out.valid),
    .i_out_ready     (o_out.ready),
    .i_out_bits      (o_out.packed_bits),
    .i_out_row_end   (o_out.row_end),
    .i_out_frame_end (o_out.frame_end)
);
